// ----- design/ihd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihd_pkg
// Shared widths, reset values and register codes of the 2x2 image downscaler.
// ----------------------------------------------------------------------------
package ihd_pkg;

    localparam int PIXEL_W      = 8;
    localparam int PAIR_W       = 9;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 4;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(640);
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(480);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } t_cfg_reg;

endpackage : ihd_pkg
`default_nettype wire

// ----- design/ihd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ihd interfaces
// Valid/ready channels of the downscaler: source pixels, reduced pixels and
// configuration register writes.
// ----------------------------------------------------------------------------
interface ihd_pix_if import ihd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface : ihd_pix_if

interface ihd_avg_if import ihd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] avg_pixel;
    logic               row_end;
    logic               frame_end;

    modport source (output valid, output avg_pixel, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input avg_pixel, input row_end, input frame_end,
                    output ready);
endinterface : ihd_avg_if

interface ihd_cfg_if import ihd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : ihd_cfg_if
`default_nettype wire

// ----- design/image_half_downscale_2x2.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// image_half_downscale_2x2
// 2x2 box-filter downscaler for an 8-bit grayscale raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix carries one source pixel per word in raster order. o_avg carries one
//   reduced pixel per 2x2 block, the floor of the block sum over four, with
//   row_end on the last pixel of a reduced row and frame_end on the last one
//   of the frame. i_cfg writes image_width (index 0) or image_height (index 1);
//   any such write restarts the frame. Other indexes are ignored. Write only
//   while the block is idle. An odd, zero or oversized dimension makes the
//   block swallow pixels and emit nothing.
// Timing:
//   one pixel per cycle sustained unless a held-off o_avg fills both result
//   slots. The pixel that completes a block has its line store read and pair
//   sum registered in the read stage, then its average in the output register.
// Reset:
//   width 640, height 480, counters at the frame start. The line store is not
//   cleared; every entry is written on an even row before an odd row reads it.
// Stall:
//   when o_avg is held off, one result waits in the output register and one
//   in the read stage; i_pix.ready drops only once both are occupied.
// ----------------------------------------------------------------------------
module image_half_downscale_2x2 import ihd_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ihd_cfg_if.sink    i_cfg,
    ihd_pix_if.sink    i_pix,
    ihd_avg_if.source  o_avg
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW         = AW + 1;
    localparam int RW         = $clog2(MAX_HEIGHT);

    // configuration
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic                    w_cfg_wr;
    logic                    w_cfg_hit;

    // frame position
    logic [CW-1:0]      r_col,  n_col;
    logic [RW-1:0]      r_row,  n_row;
    logic [PIXEL_W-1:0] r_left;

    logic               w_dims_ok;
    logic               w_last_col;
    logic               w_last_row;
    logic               w_in_acc;
    logic               w_work;
    logic               w_produce;
    logic               w_wr_en;
    logic [AW-1:0]      w_slot;
    logic [PAIR_W-1:0]  w_pair;

    // line store and read stage
    logic [PAIR_W-1:0]  r_line [LINE_DEPTH];
    logic [PAIR_W-1:0]  r_rd;
    logic [PAIR_W-1:0]  r_pair;
    logic               r_s1_valid;
    logic               r_s1_row_end;
    logic               r_s1_frame_end;

    // output register
    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_avg;
    logic               r_out_row_end;
    logic               r_out_frame_end;
    logic               w_can_take;
    logic [PAIR_W:0]    w_total;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid && i_cfg.ready;
    assign w_cfg_hit   = w_cfg_wr && (i_cfg.index == REG_IMAGE_WIDTH ||
                                      i_cfg.index == REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg.data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg.data[CFG_HEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_dims_ok = (r_width != '0) && (32'(r_width) <= 32'(MAX_WIDTH)) &&
                       (r_height != '0) && (32'(r_height) <= 32'(MAX_HEIGHT)) &&
                       !r_width[0] && !r_height[0];

    assign w_can_take  = !r_out_valid || o_avg.ready;
    assign i_pix.ready = !r_s1_valid || w_can_take;
    assign w_in_acc    = i_pix.valid && i_pix.ready;
    assign w_work      = w_in_acc && w_dims_ok;

    assign w_last_col = (32'(r_col) == 32'(r_width) - 32'd1);
    assign w_last_row = (32'(r_row) == 32'(r_height) - 32'd1);
    assign w_slot     = r_col[CW-1:1];
    assign w_pair     = {1'b0, r_left} + {1'b0, i_pix.pixel};
    assign w_wr_en    = w_work && r_col[0] && !r_row[0];
    assign w_produce  = w_work && r_col[0] && r_row[0];

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (w_last_col) begin
            n_col = '0;
            n_row = w_last_row ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (w_cfg_hit) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (w_work) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_left <= i_pix.pixel;
            end
        end
    end

    // even rows store pair sums, odd rows read them back
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line[w_slot] <= w_pair;
        end
        if (w_produce) begin
            r_rd <= r_line[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_pair         <= w_pair;
            r_s1_row_end   <= w_last_col;
            r_s1_frame_end <= w_last_col && w_last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= w_produce;
        end else if (w_can_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    assign w_total = {1'b0, r_rd} + {1'b0, r_pair};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_can_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_take && r_s1_valid) begin
            r_out_avg       <= w_total[PAIR_W:2];
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_avg.valid     = r_out_valid;
    assign o_avg.avg_pixel = r_out_avg;
    assign o_avg.row_end   = r_out_row_end;
    assign o_avg.frame_end = r_out_frame_end;

    // both result slots full and the sink stalled: no pixel may enter
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_avg.ready |-> !i_pix.ready)
        else $error("pixel accepted with both result slots full");

    a_frame_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_frame_end || r_out_row_end))
        else $error("frame_end without row_end");

    a_bad_dims_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_dims_ok |=> !r_s1_valid)
        else $error("result started under invalid dimensions");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dims_ok |-> (32'(r_row) < 32'(r_height)) && (32'(r_col) < 32'(r_width)))
        else $error("frame position beyond configured size");

endmodule : image_half_downscale_2x2
`default_nettype wire
